@@ sv/atab_pkg.sv @@
// atab_pkg: shared types and constants for the address tuple table.
// Used by atab_ctrl, atab_dp and address_tuple_table; no dependencies.
package atab_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int FIELD_W     = 16;
  localparam int OUT_W       = 9;
  localparam int SREG_W      = 15;

  localparam logic signed [FIELD_W-1:0] SCALE_STACK = -16'sd1;

  typedef enum logic [1:0] {
    CMD_FIND  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLEAN = 2'd2,
    CMD_FIX   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [FIELD_W-1:0] base_field;
    logic signed [FIELD_W-1:0] index_field;
    logic signed [FIELD_W-1:0] scale_field;
    logic signed [FIELD_W-1:0] offset_field;
    logic signed [FIELD_W-1:0] distance;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] position;
    logic             status;
    logic [OUT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] base;
    logic signed [FIELD_W-1:0] index;
    logic signed [FIELD_W-1:0] scale;
    logic signed [FIELD_W-1:0] offset;
  } tuple_t;

  localparam int TUPLE_W = $bits(tuple_t);

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the accepted beat, clear walk counters
    logic do_add;    // append (or refuse) the latched tuple
    logic issue;     // read entry at walk pointer, advance it
    logic proc;      // read data of previous issue is valid
    logic end_walk;  // walk over: commit new count for clean
    logic out_load;  // load the result register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_add;
    logic more;      // walk pointer still below count
    logic found;     // find has its answer
  } st_t;

endpackage

@@ sv/atab_ram.sv @@
// atab_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module atab_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/atab_ctrl.sv @@
// atab_ctrl: command sequencer for the address tuple table.
// Depends on atab_pkg (ctl_t, st_t).
module atab_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  output logic           result_valid,
  input  logic           result_stall,
  input  atab_pkg::st_t  st,
  output atab_pkg::ctl_t ctl
);
  import atab_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  state_t state, state_next;
  logic   rd_v;
  logic   walk_done;

  assign item_stall = (state != S_IDLE);
  assign walk_done  = (!st.more && !rd_v) || st.found;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.load   = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (st.is_add) begin
          ctl.do_add = 1'b1;
          state_next = S_FIN;
        end else begin
          ctl.issue = st.more;
          ctl.proc  = rd_v;
          if (walk_done) begin
            ctl.end_walk = 1'b1;
            state_next   = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!result_valid || !result_stall) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= ctl.issue && (state_next == S_WALK);
      if (ctl.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/atab_dp.sv @@
// atab_dp: datapath of the address tuple table: tuple RAM, count, walk
// pointers, match logic and result register. Depends on atab_pkg, atab_ram.
module atab_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [atab_pkg::SREG_W-1:0]   cfg_data,
  input  atab_pkg::item_t               item,
  input  atab_pkg::ctl_t                ctl,
  output atab_pkg::st_t                 st,
  output atab_pkg::result_t             result
);
  import atab_pkg::*;

  item_t               ireg;
  logic [SREG_W-1:0]   sreg;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    j;
  logic [ADDR_W-1:0]   proc_idx;
  logic [CNT_W-1:0]    pos;
  logic                full;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  tuple_t              wdata;
  tuple_t              rt;
  logic [TUPLE_W-1:0]  rdata;
  tuple_t              key;
  logic signed [FIELD_W-1:0] neg_sr;
  logic                is_full_now;
  logic                stack_hit;

  atab_ram #(.WIDTH(TUPLE_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign rt          = tuple_t'(rdata);
  assign key         = '{base: ireg.base_field, index: ireg.index_field,
                         scale: ireg.scale_field, offset: ireg.offset_field};
  assign neg_sr      = FIELD_W'(0) - FIELD_W'({1'b0, sreg});
  assign is_full_now = (n == CNT_W'(TABLE_DEPTH));
  assign stack_hit   = (rt.base == neg_sr) && (rt.index == '0) &&
                       (rt.scale == SCALE_STACK);

  assign st.is_add = (ireg.cmd == CMD_ADD);
  assign st.more   = (rd_idx < n);
  assign st.found  = (ireg.cmd == CMD_FIND) && (pos != '0);

  // single write port: append, compaction copy, or stack fix-up
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = key;
    if (ctl.do_add && !is_full_now) begin
      we    = 1'b1;
      waddr = n[ADDR_W-1:0];
    end else if (ctl.proc) begin
      case (ireg.cmd)
        CMD_CLEAN: begin
          if (rt.base != '0) begin
            we    = 1'b1;
            waddr = j[ADDR_W-1:0];
            wdata = rt;
          end
        end
        CMD_FIX: begin
          if (stack_hit) begin
            we           = 1'b1;
            waddr        = proc_idx;
            wdata        = rt;
            wdata.scale  = '0;
            wdata.offset = rt.offset + ireg.distance;
          end
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sreg <= '0;
      n    <= '0;
    end else begin
      if (cfg_we) begin
        sreg <= cfg_data;
      end
      if (ctl.do_add && !is_full_now) begin
        n <= n + CNT_W'(1);
      end
      if (ctl.end_walk && (ireg.cmd == CMD_CLEAN)) begin
        n <= j;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ireg   <= item;
      rd_idx <= '0;
      j      <= '0;
      pos    <= '0;
      full   <= 1'b0;
    end else begin
      if (ctl.issue) begin
        rd_idx   <= rd_idx + CNT_W'(1);
        proc_idx <= rd_idx[ADDR_W-1:0];
      end
      if (ctl.do_add) begin
        if (is_full_now) begin
          full <= 1'b1;
        end else begin
          pos <= n + CNT_W'(1);
        end
      end
      if (ctl.proc) begin
        if (ireg.cmd == CMD_FIND && pos == '0 && rt == key) begin
          pos <= CNT_W'(proc_idx) + CNT_W'(1);
        end
        if (ireg.cmd == CMD_CLEAN && rt.base != '0) begin
          j <= j + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      result.position    <= (ireg.cmd == CMD_FIND || ireg.cmd == CMD_ADD) ?
                            OUT_W'(pos) : '0;
      result.status      <= full;
      result.entry_count <= OUT_W'(n);
    end
  end

endmodule

@@ sv/address_tuple_table.sv @@
// address_tuple_table: ordered table of (base, index, scale, offset) tuples.
// Add is done on entering the walk, then its result is registered; find, clean
// and fix walk the n stored entries first (find stops at its hit).
// Throughput: one command at a time, bounded by the walk over the one read port
// of the tuple RAM (one entry per cycle); the next beat is taken while a result
// waits. Reset (rst, synchronous) empties the table and clears stack_register;
// RAM contents are not cleared and need no clearing pass.
module address_tuple_table (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: stack_register
  input  logic                        cfg_we,
  input  logic [atab_pkg::SREG_W-1:0] cfg_data,
  // command beats
  input  logic                        item_valid,
  output logic                        item_stall,
  input  atab_pkg::item_t             item,
  // result beats
  output logic                        result_valid,
  input  logic                        result_stall,
  output atab_pkg::result_t           result
);
  import atab_pkg::*;

  ctl_t ctl;
  st_t  st;

  // Controller: idle -> walk (add is done in its first walk cycle) -> finish.
  // The walk issues one RAM read per cycle and processes the data in the following
  // cycle, so reads run one entry ahead of compaction and fix-up writes.
  atab_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .st           (st),
    .ctl          (ctl)
  );

  // Datapath: tuple RAM, entry count, walk pointers, result register.
  atab_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .ctl      (ctl),
    .st       (st),
    .result   (result)
  );

  // one command in flight: an accepted beat closes the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("input taken while a command is in flight");

  // the walk never reads past the stored entries
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.issue |-> st.more)
    else $error("read issued beyond entry count");

  // a refused add reports no position
  a_full_no_pos: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status) |-> (result.position == '0))
    else $error("full status with nonzero position");

  // a result is loaded only into a free or draining output register
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!result_valid || !result_stall))
    else $error("result register overwritten while stalled");

endmodule

@@ tb/address_tuple_table_tb.sv @@
// address_tuple_table_tb: self-checking bench for the address tuple table.
// Sends command beats, predicts every result beat with a local copy of the
// table and checks them in order. Needs atab_pkg and address_tuple_table.
module address_tuple_table_tb;
  import atab_pkg::*;

  // Cycle limit for the whole run, set generously.
  localparam int RUN_LIMIT  = 3_000_000;
  // A full walk plus the result pipe, waited out once at the very end.
  localparam int DRAIN_TAIL = TABLE_DEPTH + 16;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_we       = 1'b0;
  logic [SREG_W-1:0] cfg_data     = '0;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  item_t             item         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;

  int send_idle_pct = 0;   // chance per cycle that the command side holds off
  int recv_idle_pct = 0;   // chance per cycle that the result side stalls
  int err_count     = 0;
  int cycle_count   = 0;
  int cfg_round     = 0;

  // Local copy of the block state, advanced once per accepted command beat.
  tuple_t            tab_model [TABLE_DEPTH];
  int                tab_used        = 0;
  logic [SREG_W-1:0] stack_reg_model = '0;

  // Result beats owed by the block, oldest first.
  result_t pending_results [$];
  result_t want;

  address_tuple_table u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result-side back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    err_count++;
  endtask

  // Result checker. Everything here reads pre-edge values, the same ones the
  // DUT sees, so the accept decision matches the DUT's exactly.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want = pending_results.pop_front();
        if (result.position !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    result.position, want.position));
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0b, expected %0b",
                                    result.status, want.status));
        if (result.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    result.entry_count, want.entry_count));
      end
    end
  end

  // 16-bit pattern of -stack_register: the base of a stack-relative tuple.
  function automatic logic [FIELD_W-1:0] stack_base();
    return 16'h0000 - {1'b0, stack_reg_model};
  endfunction

  // Applies one command to the local table and returns the result it owes.
  function automatic result_t table_step(item_t it);
    result_t r;
    tuple_t  t;
    int      kept;
    r = '0;
    t = {it.base_field, it.index_field, it.scale_field, it.offset_field};
    case (it.cmd)
      CMD_FIND: begin
        // first match wins; later duplicates are never reported
        for (int i = 0; i < tab_used; i++)
          if (r.position == '0 && tab_model[i] == t) r.position = OUT_W'(i + 1);
      end
      CMD_ADD: begin
        if (tab_used >= TABLE_DEPTH) begin
          r.status = 1'b1;        // full: nothing stored, position stays 0
        end else begin
          tab_model[tab_used] = t;
          tab_used++;
          r.position = OUT_W'(tab_used);
        end
      end
      CMD_CLEAN: begin
        // compact in place, order of survivors kept
        kept = 0;
        for (int i = 0; i < tab_used; i++) begin
          if (tab_model[i].base != '0) begin
            tab_model[kept] = tab_model[i];
            kept++;
          end
        end
        tab_used = kept;
      end
      default: begin
        for (int i = 0; i < tab_used; i++) begin
          if (tab_model[i].base == stack_base() && tab_model[i].index == '0 &&
              tab_model[i].scale == SCALE_STACK) begin
            tab_model[i].scale  = '0;
            tab_model[i].offset = tab_model[i].offset + it.distance;  // wraps
          end
        end
      end
    endcase
    r.entry_count = OUT_W'(tab_used);
    return r;
  endfunction

  function automatic item_t mk_item(cmd_e op, tuple_t t, logic [FIELD_W-1:0] delta);
    item_t it;
    it.cmd          = op;
    it.base_field   = t.base;
    it.index_field  = t.index;
    it.scale_field  = t.scale;
    it.offset_field = t.offset;
    it.distance     = delta;
    return it;
  endfunction

  function automatic logic [FIELD_W-1:0] extreme_value();
    case ($urandom_range(3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Random tuple biased toward the interesting shapes: zero bases for clean,
  // stack-relative bases with index 0 and scale -1 for fix, edge offsets.
  function automatic tuple_t rand_tuple();
    tuple_t t;
    t = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: t.base = '0;
      4, 5, 6:    t.base = stack_base();
      7:          t.base = extreme_value();
      default:    ;
    endcase
    if ($urandom_range(9) < 6) t.index = '0;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: t.scale = SCALE_STACK;
      10, 11, 12:                   t.scale = '0;
      default:                      ;
    endcase
    if ($urandom_range(4) == 0) t.offset = extreme_value();
    return t;
  endfunction

  // Mostly a tuple that is stored (hit), sometimes one bit off (near miss).
  function automatic tuple_t find_target();
    tuple_t t;
    int     k;
    if (tab_used != 0 && $urandom_range(9) < 7) begin
      t = tab_model[$urandom_range(tab_used - 1)];
      if ($urandom_range(4) == 0) begin
        k    = $urandom_range(TUPLE_W - 1);
        t[k] = ~t[k];
      end
    end else begin
      t = rand_tuple();
    end
    return t;
  endfunction

  // Sends one command beat. Valid is left high after acceptance; the next
  // call either keeps it up with a new payload or drops it for a gap, so
  // valid never gets two assignments in one step.
  task automatic send_beat(input item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(table_step(it));
  endtask

  // Unused fields carry noise: find/add ignore distance, clean/fix the tuple.
  task automatic do_add(input tuple_t t);
    send_beat(mk_item(CMD_ADD, t, FIELD_W'($urandom)));
  endtask

  task automatic do_find(input tuple_t t);
    send_beat(mk_item(CMD_FIND, t, FIELD_W'($urandom)));
  endtask

  task automatic do_clean();
    send_beat(mk_item(CMD_CLEAN, {$urandom, $urandom}, FIELD_W'($urandom)));
  endtask

  task automatic do_fix(input logic [FIELD_W-1:0] dist_amt);
    send_beat(mk_item(CMD_FIX, {$urandom, $urandom}, dist_amt));
  endtask

  // Stop sending and wait for every owed result beat.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic set_stack_reg(input logic [SREG_W-1:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we          <= 1'b0;
    stack_reg_model  = v;
  endtask

  // All three walking commands on an empty table.
  task automatic test_empty_table();
    do_find({16'h0000, 16'h0000, 16'h0000, 16'h0000});
    do_clean();
    do_fix(16'h7FFF);
  endtask

  // Edge values in every field, a base-zero entry, a duplicate, hit and miss.
  task automatic test_add_find();
    do_add({16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000});
    do_add({16'h0000, 16'h7FFF, 16'h8000, 16'h1234});
    do_add({16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
    do_add({16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000});   // duplicate of entry 1
    do_find({16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000});  // first copy wins
    do_find({16'h8000, 16'h7FFF, 16'h0000, 16'hFFFE});  // offset off by one
  endtask

  // Fix only touches base == -stack_register, index 0, scale -1.
  task automatic test_stack_fix();
    set_stack_reg('1);                                  // base 16'h8001
    do_add({16'h8001, 16'h0000, 16'hFFFF, 16'h7FFF});   // offset about to wrap
    do_add({16'h8001, 16'h0001, 16'hFFFF, 16'h0000});   // index not zero
    do_add({16'h8001, 16'h0000, 16'hFFFE, 16'h0000});   // scale not -1
    do_add({16'h8002, 16'h0000, 16'hFFFF, 16'h0000});   // other base
    do_fix(16'h0001);
    do_find({16'h8001, 16'h0000, 16'h0000, 16'h8000});  // rewritten entry
    do_fix(16'h8000);                                   // nothing left to fix
    set_stack_reg('0);                                  // -0: base zero now
    do_add({16'h0000, 16'h0000, 16'hFFFF, 16'h0005});
    do_fix(16'hFFFF);                                   // offset 5 -> 4
  endtask

  // Clean drops base-zero entries and shifts the rest down in order.
  task automatic test_clean();
    do_clean();
    do_find({16'h0000, 16'h0000, 16'h0000, 16'h0004});  // removed
    do_find({16'h8002, 16'h0000, 16'hFFFF, 16'h0000});  // moved up one
  endtask

  // Fill to capacity, get an add refused, then walk the full table.
  task automatic test_full_table();
    tuple_t t;
    while (tab_used < TABLE_DEPTH) begin
      t = rand_tuple();
      if (tab_used % 16 != 0) t.base = '0;  // keep most removable by clean
      do_add(t);
    end
    do_add(rand_tuple());
    do_find(tab_model[TABLE_DEPTH - 1]);
    do_find(find_target());
    do_fix(extreme_value());
    do_clean();
  endtask

  // Random command mix in three segments, each under its own stack register.
  task automatic test_random(input int n_beats);
    logic [SREG_W-1:0] v;
    for (int seg = 0; seg < 3; seg++) begin
      case (cfg_round % 4)
        0:       v = '0;
        1:       v = '1;
        2:       v = SREG_W'(1);
        default: v = SREG_W'($urandom);
      endcase
      cfg_round++;
      set_stack_reg(v);
      for (int k = 0; k < n_beats / 3; k++) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6:     do_add(rand_tuple());
          7, 8, 9, 10, 11, 12, 13: do_find(find_target());
          14, 15, 16:              do_clean();
          default: begin
            if ($urandom_range(3) == 0) do_fix(extreme_value());
            else do_fix(FIELD_W'($urandom));
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver stalls heavily
    send_idle_pct = 25;
    recv_idle_pct = 69;
    test_empty_table();
    test_add_find();
    test_stack_fix();
    test_clean();
    test_random(240);

    // the other way round
    send_idle_pct = 69;
    recv_idle_pct = 25;
    test_full_table();
    test_random(240);

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(240);

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/atab_pkg.sv
sv/atab_ram.sv
sv/atab_ctrl.sv
sv/atab_dp.sv
sv/address_tuple_table.sv
tb/address_tuple_table_tb.sv
